// ===== rtl/mmp_pkg.sv =====
// package for the modular matrix power block
// sizes, register indexes and sequencer states; no dependencies
package mmp_pkg;
   localparam int MAX_N  = 8;
   localparam int ELEM_W = 16;
   localparam int CELLS  = MAX_N * MAX_N;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int IDX_W  = $clog2(MAX_N);
   localparam int DIV_W  = 2 * ELEM_W + $clog2(MAX_N);
   localparam int CNT_W  = $clog2(DIV_W);

   localparam logic [1:0] REG_SIZE    = 2'd0;
   localparam logic [1:0] REG_POWER   = 2'd1;
   localparam logic [1:0] REG_MODULUS = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INIT_RD,
      S_INIT_LD,
      S_INIT_DIV,
      S_EXP,
      S_MUL_RD,
      S_MUL_MP,
      S_MUL_AC,
      S_MUL_DIV,
      S_COPY_RD,
      S_COPY_WR,
      S_OUT_RD,
      S_OUT
   } state_type;
endpackage

// ===== rtl/modular_matrix_power.sv =====
// modular matrix power: loads an n-by-n matrix one beat at a time, then
// returns A^power mod modulus in row-major order
// depends on mmp_pkg
//
// usage: load the matrix row-major, one element per start beat while busy
// is low. the beat carrying the last element raises busy; all other load
// beats leave busy low. the user writes configuration (size, power, modulus)
// on the csr channel, always ready, only while idle; the block itself does not enforce it.
// the power is formed by square-and-multiply over block memories: each
// product element sums its inner terms and then takes a serial remainder,
// and each product is followed by a copy back, with up to two products
// per exponent bit, after an initial reduction of the loaded matrix.
// results then leave on rsp_valid, one beat each, last flagged; the
// receiver cannot stall. busy falls the cycle after the last result beat.
// reset clears the sequencer, load count and registers to size 2,
// power 1, modulus 10000; the matrix memories need no clearing.
module modular_matrix_power (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [mmp_pkg::ELEM_W-1:0]  req_elem,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_out_elem,
   output logic [2:0]                  rsp_out_row,
   output logic [2:0]                  rsp_out_col,
   output logic                        rsp_out_last,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [1:0]                  csr_index,
   input  logic [31:0]                 csr_data
);
   import mmp_pkg::*;

   state_type state_ff, state_in;
   logic [3:0]  size_ff;
   logic [31:0] pow_ff;
   logic [15:0] mod_ff;
   logic [6:0]  lc_ff, lc_in;
   logic [31:0] e_ff, e_in;
   logic        did_ff, did_in;
   logic        sq_ff, sq_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DIV_W-1:0] sum_ff, sum_in, div_ff, div_in;
   logic [2*ELEM_W-1:0] prod_ff, prod_in;
   logic [15:0] rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic [ELEM_W-1:0] base_mem [CELLS];
   logic [ELEM_W-1:0] acc_mem  [CELLS];
   logic [ELEM_W-1:0] scr_mem  [CELLS];
   logic [ELEM_W-1:0] tmp_mem  [CELLS];
   logic [ELEM_W-1:0] base_rd, acc_rd, scr_a_rd, scr_b_rd, tmp_rd;

   logic [3:0]  n_eff;
   logic [15:0] md_eff;
   logic [6:0]  cells;
   logic [ADDR_W-1:0] a_ij, a_ik, a_kj, acc_ra, scr_ra;
   logic        acc_we, scr_we, tmp_we, base_we;
   logic [ELEM_W-1:0] acc_wd, scr_wd;
   logic [16:0] rem_t;
   logic [15:0] rem_nxt;
   logic        div_done, ij_last;
   logic [ELEM_W-1:0] x_rd;
   logic [DIV_W-1:0]  sum_p;

   assign n_eff  = (size_ff == 4'd0) ? 4'd1 : ((size_ff > 4'(MAX_N)) ? 4'(MAX_N) : size_ff);
   assign md_eff = (mod_ff == 16'd0) ? 16'd1 : mod_ff;
   assign cells  = 7'({3'b000, n_eff} * {3'b000, n_eff});
   assign a_ij   = ADDR_W'({3'b000, i_ff} * {2'b00, n_eff}) + ADDR_W'(j_ff);
   assign a_ik   = ADDR_W'({3'b000, i_ff} * {2'b00, n_eff}) + ADDR_W'(k_ff);
   assign a_kj   = ADDR_W'({3'b000, k_ff} * {2'b00, n_eff}) + ADDR_W'(j_ff);
   assign ij_last = ({1'b0, i_ff} == n_eff - 4'd1) && ({1'b0, j_ff} == n_eff - 4'd1);
   assign rem_t  = {rem_ff, div_ff[DIV_W-1]};
   assign rem_nxt = (rem_t >= {1'b0, md_eff}) ? 16'(rem_t - {1'b0, md_eff}) : rem_t[15:0];
   assign div_done = (cnt_ff == CNT_W'(DIV_W - 1));
   assign x_rd   = sq_ff ? scr_a_rd : acc_rd;
   assign sum_p  = sum_ff + DIV_W'(prod_ff);
   assign base_we = start && !busy;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_out_elem = 16'(acc_rd);
   assign rsp_out_row  = 3'(i_ff);
   assign rsp_out_col  = 3'(j_ff);
   assign rsp_out_last = rsp_valid && ij_last;

   // memories
   always_ff @(posedge clock) begin
      if (base_we) begin
         base_mem[lc_ff[ADDR_W-1:0]] <= req_elem;
      end
      if (acc_we) begin
         acc_mem[a_ij] <= acc_wd;
      end
      if (scr_we) begin
         scr_mem[a_ij] <= scr_wd;
      end
      if (tmp_we) begin
         tmp_mem[a_ij] <= ELEM_W'(rem_nxt);
      end
      base_rd  <= base_mem[a_ij];
      acc_rd   <= acc_mem[acc_ra];
      scr_a_rd <= scr_mem[scr_ra];
      scr_b_rd <= scr_mem[a_kj];
      tmp_rd   <= tmp_mem[a_ij];
   end

   // configuration and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         size_ff  <= 4'd2;
         pow_ff   <= 32'd1;
         mod_ff   <= 16'd10000;
         lc_ff    <= '0;
         e_ff     <= '0;
         did_ff   <= 1'b0;
         sq_ff    <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         lc_ff    <= lc_in;
         e_ff     <= e_in;
         did_ff   <= did_in;
         sq_ff    <= sq_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         cnt_ff   <= cnt_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SIZE:    size_ff <= csr_data[3:0];
               REG_POWER:   pow_ff  <= csr_data;
               REG_MODULUS: mod_ff  <= csr_data[15:0];
               default:     ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      sum_ff  <= sum_in;
      div_ff  <= div_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   always_comb begin
      state_in = state_ff;
      lc_in    = lc_ff;
      e_in     = e_ff;
      did_in   = did_ff;
      sq_in    = sq_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      div_in   = div_ff;
      prod_in  = prod_ff;
      rem_in   = rem_ff;
      acc_we   = 1'b0;
      scr_we   = 1'b0;
      tmp_we   = 1'b0;
      acc_wd   = '0;
      scr_wd   = '0;
      acc_ra   = a_ij;
      scr_ra   = a_ik;
      if (state_ff == S_MUL_RD) begin
         acc_ra = a_ik;
      end
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (lc_ff + 7'd1 >= cells) begin
                  lc_in    = '0;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = S_INIT_RD;
               end else begin
                  lc_in = lc_ff + 7'd1;
               end
            end
         end
         S_INIT_RD: state_in = S_INIT_LD;
         S_INIT_LD: begin
            div_in   = DIV_W'(base_rd);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = S_INIT_DIV;
         end
         S_INIT_DIV: begin
            rem_in = rem_nxt;
            div_in = div_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_done) begin
               scr_we = 1'b1;
               scr_wd = ELEM_W'(rem_nxt);
               acc_we = 1'b1;
               acc_wd = ((i_ff == j_ff) && (md_eff != 16'd1)) ? ELEM_W'(1) : '0;
               if (ij_last) begin
                  e_in     = pow_ff;
                  did_in   = 1'b0;
                  state_in = S_EXP;
               end else begin
                  state_in = S_INIT_RD;
               end
            end
         end
         S_EXP: begin
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            sum_in = '0;
            if (e_ff == 32'd0) begin
               state_in = S_OUT_RD;
            end else if (e_ff[0] && !did_ff) begin
               sq_in    = 1'b0;
               did_in   = 1'b1;
               state_in = S_MUL_RD;
            end else begin
               e_in   = e_ff >> 1;
               did_in = 1'b0;
               if (e_ff[31:1] != 31'd0) begin
                  sq_in    = 1'b1;
                  state_in = S_MUL_RD;
               end
            end
         end
         S_MUL_RD: state_in = S_MUL_MP;
         S_MUL_MP: begin
            prod_in  = x_rd * scr_b_rd;
            state_in = S_MUL_AC;
         end
         S_MUL_AC: begin
            if ({1'b0, k_ff} == n_eff - 4'd1) begin
               div_in   = sum_p;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_MUL_DIV;
            end else begin
               sum_in   = sum_p;
               k_in     = k_ff + IDX_W'(1);
               state_in = S_MUL_RD;
            end
         end
         S_MUL_DIV: begin
            rem_in = rem_nxt;
            div_in = div_ff << 1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_done) begin
               tmp_we = 1'b1;
               sum_in = '0;
               k_in   = '0;
               if (ij_last) begin
                  state_in = S_COPY_RD;
               end else begin
                  state_in = S_MUL_RD;
               end
            end
         end
         S_COPY_RD: state_in = S_COPY_WR;
         S_COPY_WR: begin
            acc_we = !sq_ff;
            scr_we = sq_ff;
            acc_wd = tmp_rd;
            scr_wd = tmp_rd;
            if (ij_last) begin
               state_in = S_EXP;
            end else begin
               state_in = S_COPY_RD;
            end
         end
         S_OUT_RD: state_in = S_OUT;
         S_OUT: begin
            if (ij_last) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_OUT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // row-major walk shared by init, product, copy and output
      if ((state_ff == S_INIT_DIV && div_done) || (state_ff == S_MUL_DIV && div_done) ||
          state_ff == S_COPY_WR || state_ff == S_OUT) begin
         if (ij_last) begin
            i_in = '0;
            j_in = '0;
         end else if ({1'b0, j_ff} == n_eff - 4'd1) begin
            j_in = '0;
            i_in = i_ff + IDX_W'(1);
         end else begin
            j_in = j_ff + IDX_W'(1);
         end
      end
   end
endmodule

// ===== rtl/mmp_checker.sv =====
// port-level checks for the modular matrix power block
// depends on modular_matrix_power, attached by bind
module mmp_checker (
   input logic clock,
   input logic reset,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_out_last
);
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result beat while idle");
   a_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result beats back to back");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_last |=> !busy) else $error("busy after last beat");
   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_out_last |=> busy) else $error("idle before last beat");
   a_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid) else $error("busy after reset");
endmodule

bind modular_matrix_power mmp_checker u_mmp_checker (
   .clock        (clock),
   .reset        (reset),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_out_last (rsp_out_last)
);

// ===== tb/sv/modular_matrix_power_test.sv =====
// self-checking testbench for modular_matrix_power: directed table, then random matrices
// under several sender idling phases; depends on mmp_pkg and the modular_matrix_power rtl
`timescale 1ns / 1ps

module modular_matrix_power_test;
   import mmp_pkg::*;

   localparam int WATCHDOG_LIMIT = 600000;
   localparam int RANDOM_ITEMS   = 500;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   typedef struct {
      logic [15:0] elem;
      logic [2:0]  row;
      logic [2:0]  col;
      logic        last;
   } result_beat_type;

   typedef struct {
      bit          is_cfg;
      logic [1:0]  index;
      logic [31:0] data;
      int          count;
      logic [15:0] elem;
      int          exp_all;
   } stim_row_type;

   logic clock, reset, start, busy;
   logic [ELEM_W-1:0] req_elem;
   logic rsp_valid, rsp_out_last;
   logic [15:0] rsp_out_elem;
   logic [2:0] rsp_out_row, rsp_out_col;
   logic csr_valid, csr_ready;
   logic [1:0] csr_index;
   logic [31:0] csr_data;

   modular_matrix_power dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_elem(req_elem),
      .rsp_valid(rsp_valid), .rsp_out_elem(rsp_out_elem), .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col), .rsp_out_last(rsp_out_last), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow copy of the block
   logic [3:0]  size_reg;
   logic [31:0] power_reg;
   logic [15:0] modulus_reg;
   int unsigned base_m[CELLS];
   int unsigned acc_m[CELLS];
   int unsigned square_m[CELLS];
   logic [6:0]  loaded;

   result_beat_type expected_q[$];
   int errors, matrices, beats_seen, elems_sent, idle_cycles;
   int idle_pct;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d (beat %0d)", what, got, want, beats_seen);
      errors++;
   endtask

   // prod = x * y mod md over n-by-n, stride n; acc_sel picks acc*square, else square*square
   function automatic void matrix_product(input bit acc_sel, input int unsigned n,
                                          input int unsigned md);
      int unsigned tmp[CELLS];
      longint unsigned s;
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            s = 0;
            for (int k = 0; k < n; k++) begin
               s += longint'(acc_sel ? acc_m[i*n+k] : square_m[i*n+k]) * square_m[k*n+j];
               s %= md;
            end
            tmp[i*n+j] = int'(s);
         end
      end
      for (int c = 0; c < n*n; c++) begin
         if (acc_sel) acc_m[c] = tmp[c];
         else square_m[c] = tmp[c];
      end
   endfunction

   function automatic void predict_power(input logic [15:0] v);
      int unsigned n, md, cells;
      logic [31:0] e;
      result_beat_type b;
      n = (size_reg == 0) ? 1 : ((size_reg > MAX_N) ? MAX_N : size_reg);
      md = (modulus_reg == 0) ? 1 : modulus_reg;
      cells = n * n;
      if (loaded < CELLS) base_m[loaded] = v;
      loaded = loaded + 7'd1;
      if (loaded < cells) return;
      loaded = '0;
      for (int c = 0; c < cells; c++) square_m[c] = base_m[c] % md;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            acc_m[i*n+j] = (i == j) ? (1 % md) : 0;
      e = power_reg;
      while (e != 0) begin
         if (e[0]) matrix_product(1'b1, n, md);
         e = e >> 1;
         if (e != 0) matrix_product(1'b0, n, md);
      end
      for (int c = 0; c < cells; c++) begin
         b.elem = acc_m[c][15:0];
         b.row = 3'(c / n);
         b.col = 3'(c % n);
         b.last = (c + 1 == cells);
         expected_q.push_back(b);
      end
      matrices++;
   endfunction

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0 || busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_SIZE:    size_reg    = val[3:0];
         REG_POWER:   power_reg   = val;
         REG_MODULUS: modulus_reg = val[15:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_elem(input logic [15:0] v);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_elem <= v;
      do @(posedge clock); while (busy);
      predict_power(v);
      elems_sent++;
   endtask

   // rsp sampled before the edge updates it
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_out_elem, 0);
         end else begin
            if (rsp_out_elem != expected_q[0].elem)
               report_mismatch("elem", rsp_out_elem, expected_q[0].elem);
            if (rsp_out_row != expected_q[0].row)
               report_mismatch("row", rsp_out_row, expected_q[0].row);
            if (rsp_out_col != expected_q[0].col)
               report_mismatch("col", rsp_out_col, expected_q[0].col);
            if (rsp_out_last != expected_q[0].last)
               report_mismatch("last", rsp_out_last, expected_q[0].last);
            void'(expected_q.pop_front());
         end
         beats_seen++;
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d quiet cycles", idle_cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   stim_row_type table_rows[] = '{
      '{0, REG_SIZE, 0, 4, 16'd5, 5},
      '{1, REG_MODULUS, 32'd0, 0, 0, -1},
      '{0, REG_SIZE, 0, 4, 16'hFFFF, 0},
      '{1, REG_SIZE, 32'd1, 0, 0, -1},
      '{1, REG_POWER, 32'd0, 0, 0, -1},
      '{1, REG_MODULUS, 32'd65535, 0, 0, -1},
      '{0, REG_SIZE, 0, 1, 16'd1234, 1},
      '{1, REG_SIZE, 32'd2, 0, 0, -1},
      '{1, REG_POWER, 32'hFFFF_FFFF, 0, 0, -1},
      '{0, REG_SIZE, 0, 2, 16'hFFFF, -1},
      '{0, REG_SIZE, 0, 2, 16'h0000, -1},
      '{1, REG_UNUSED, 32'hDEAD_BEEF, 0, 0, -1},
      '{1, REG_SIZE, 32'd0, 0, 0, -1},
      '{1, REG_POWER, 32'd1, 0, 0, -1},
      '{0, REG_SIZE, 0, 1, 16'hFFFF, 0},
      '{1, REG_SIZE, 32'd15, 0, 0, -1},
      '{1, REG_POWER, 32'd2, 0, 0, -1},
      '{1, REG_MODULUS, 32'd65521, 0, 0, -1},
      '{0, REG_SIZE, 0, 64, 16'hFFFF, -1},
      '{1, REG_SIZE, 32'd3, 0, 0, -1},
      '{0, REG_SIZE, 0, 5, 16'h8001, -1},
      '{1, REG_SIZE, 32'd2, 0, 0, -1},
      '{0, REG_SIZE, 0, 1, 16'h7FFE, -1},
      '{1, REG_POWER, 32'd5, 0, 0, -1},
      '{1, REG_MODULUS, 32'd7, 0, 0, -1}
   };

   initial begin
      int unsigned n, pick, first;
      reset = 1'b1; start = 1'b0; req_elem = '0;
      csr_valid = 1'b0; csr_index = REG_SIZE; csr_data = '0;
      errors = 0; matrices = 0; beats_seen = 0; elems_sent = 0; idle_cycles = 0;
      idle_pct = 0;
      size_reg = 4'd2; power_reg = 32'd1; modulus_reg = 16'd10000; loaded = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[r]) begin
         if (table_rows[r].is_cfg) begin
            wait_idle();
            write_reg(table_rows[r].index, table_rows[r].data);
         end else begin
            for (int k = 0; k < table_rows[r].count; k++) begin
               first = expected_q.size();
               send_elem(table_rows[r].elem);
               if (table_rows[r].exp_all >= 0)
                  for (int q = first; q < expected_q.size(); q++)
                     expected_q[q].elem = 16'(table_rows[r].exp_all);
            end
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         idle_pct = (phase == 0) ? 0 : ((phase == 1) ? 64 : 35);
         while (elems_sent < (phase + 1) * RANDOM_ITEMS / 3) begin
            wait_idle();
            pick = $urandom_range(99);
            n = (pick < 70) ? $urandom_range(1, 3) :
                ((pick < 94) ? $urandom_range(4, 5) : $urandom_range(6, 8));
            if ($urandom_range(19) == 0) n = $urandom_range(1) ? 0 : $urandom_range(9, 15);
            write_reg(REG_SIZE, n);
            if (n == 0 || n > MAX_N) n = (n == 0) ? 1 : MAX_N;
            pick = $urandom_range(99);
            if (n <= 2 && pick < 10) write_reg(REG_POWER, $urandom());
            else if (n <= 2 && pick < 15) write_reg(REG_POWER, 32'hFFFF_FFFF);
            else if (n <= 3) write_reg(REG_POWER, $urandom_range(0, 24));
            else write_reg(REG_POWER, $urandom_range(0, 6));
            pick = $urandom_range(99);
            if (pick < 40) write_reg(REG_MODULUS, $urandom_range(1, 65535));
            else if (pick < 60) write_reg(REG_MODULUS, 65535);
            else if (pick < 85) write_reg(REG_MODULUS, $urandom_range(1, 20));
            else if (pick < 92) write_reg(REG_MODULUS, 0);
            else write_reg(REG_MODULUS, $urandom_range(32768, 65535));
            // occasionally a broken load: the size moves part way through
            if ($urandom_range(19) == 0 && n > 1) begin
               for (int k = 0; k < $urandom_range(1, n*n - 1); k++) send_elem($urandom());
               wait_idle();
               write_reg(REG_SIZE, $urandom_range(1, 4));
            end
            while (expected_q.size() == 0) send_elem($urandom());
         end
      end

      wait_idle();
      repeat (100) @(posedge clock);
      $display("covered %0d matrices from %0d element beats, %0d result beats checked",
               matrices, elems_sent, beats_seen);
      $display("sizes 1 to 8, out-of-range sizes, powers 0 to all ones, moduli 0 to 65535");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches, %0d results never seen", errors, expected_q.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
rtl/mmp_pkg.sv
rtl/modular_matrix_power.sv
rtl/mmp_checker.sv
tb/sv/modular_matrix_power_test.sv
